### hdl/i2c_master_transfer_sequencer_defines.svh
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Shared macros for the concurrent checks on the sequencer ports.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### hdl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Types, status codes and register indexes shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int unsigned CountWidth = 16;

  localparam logic [7:0] StBusError  = 8'h00;
  localparam logic [7:0] StStart     = 8'h08;
  localparam logic [7:0] StRestart   = 8'h10;
  localparam logic [7:0] StAddrWAck  = 8'h18;
  localparam logic [7:0] StDataWAck  = 8'h28;
  localparam logic [7:0] StArbLost   = 8'h38;
  localparam logic [7:0] StAddrRAck  = 8'h40;
  localparam logic [7:0] StDataRAck  = 8'h50;
  localparam logic [7:0] StDataRNack = 8'h58;

  localparam logic [8:0] DoneRunning = 9'h100;

  localparam logic [1:0] RegSlaveAddress  = 2'd0;
  localparam logic [1:0] RegReadMode      = 2'd1;
  localparam logic [1:0] RegByteCount     = 2'd2;
  localparam logic [1:0] RegSclHalfPeriod = 2'd3;

  localparam logic ReqStart = 1'b0;

  typedef enum logic [3:0] {
    OP_START_REQ  = 4'd0,
    OP_ADDR       = 4'd1,
    OP_ADDR_R_ACK = 4'd2,
    OP_DATA_R_ACK = 4'd3,
    OP_DATA_R_NAK = 4'd4,
    OP_ADDR_W_ACK = 4'd5,
    OP_DATA_W_ACK = 4'd6,
    OP_ARB_LOST   = 4'd7,
    OP_FINISH     = 4'd8
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] status;
    logic [7:0] rx;
    logic [7:0] tx;
  } item_t;

  typedef struct packed {
    logic       enable_and_start;
    logic       set_start;
    logic       clear_start;
    logic       set_ack;
    logic       clear_ack;
    logic       clear_flag;
    logic       send_stop;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [8:0] done_status;
  } result_t;

endpackage

### hdl/i2cmts_front.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer front end
// Accepts request items and classifies each one into an operation code.
// ----------------------------------------------------------------------------
module i2cmts_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        status_code_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        tx_byte_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output i2cmts_pkg::item_t push_item_o
);

  i2cmts_pkg::op_e op;

  always_comb begin
    if (req_type_i == i2cmts_pkg::ReqStart) begin
      op = i2cmts_pkg::OP_START_REQ;
    end else begin
      case (status_code_i)
        i2cmts_pkg::StStart:     op = i2cmts_pkg::OP_ADDR;
        i2cmts_pkg::StRestart:   op = i2cmts_pkg::OP_ADDR;
        i2cmts_pkg::StAddrRAck:  op = i2cmts_pkg::OP_ADDR_R_ACK;
        i2cmts_pkg::StDataRAck:  op = i2cmts_pkg::OP_DATA_R_ACK;
        i2cmts_pkg::StDataRNack: op = i2cmts_pkg::OP_DATA_R_NAK;
        i2cmts_pkg::StAddrWAck:  op = i2cmts_pkg::OP_ADDR_W_ACK;
        i2cmts_pkg::StDataWAck:  op = i2cmts_pkg::OP_DATA_W_ACK;
        i2cmts_pkg::StArbLost:   op = i2cmts_pkg::OP_ARB_LOST;
        i2cmts_pkg::StBusError:  op = i2cmts_pkg::OP_FINISH;
        default:                 op = i2cmts_pkg::OP_FINISH;
      endcase
    end
  end

  assign push_valid_o       = in_valid_i;
  assign in_ready_o         = push_ready_i;
  assign push_item_o.op     = op;
  assign push_item_o.status = status_code_i;
  assign push_item_o.rx     = rx_byte_i;
  assign push_item_o.tx     = tx_byte_i;

endmodule

### hdl/i2cmts_queue.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module i2cmts_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  i2cmts_pkg::item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output i2cmts_pkg::item_t pop_item_o
);

  i2cmts_pkg::item_t entry_q [2];
  logic [1:0]        count_q, count_d;
  logic              wptr_q, wptr_d;
  logic              rptr_q, rptr_d;
  logic              push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/i2cmts_back.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer back end
// Carries out queued operations against the transfer state and registers
// the resulting control actions for the output channel.
// ----------------------------------------------------------------------------
module i2cmts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          slave_address_i,
  input  logic                read_mode_i,
  input  logic [15:0]         byte_count_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  i2cmts_pkg::item_t   pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cmts_pkg::result_t result_o
);

  localparam int unsigned CW = i2cmts_pkg::CountWidth;

  logic                busy_q, busy_d;
  logic [CW-1:0]       bytes_done_q, bytes_done_d;
  logic                out_valid_q, out_valid_d;
  i2cmts_pkg::result_t result_q, result_d;
  logic [CW-1:0]       limit, bytes_inc;
  logic                at_max, inc_at_max, limit_now, limit_inc;
  logic                pop;

  assign pop         = pop_valid_i && pop_ready_o;
  assign pop_ready_o = !out_valid_q || out_ready_i;

  assign limit      = CW'(byte_count_i);
  assign at_max     = (bytes_done_q == {CW{1'b1}});
  assign bytes_inc  = at_max ? bytes_done_q : bytes_done_q + CW'(1);
  assign inc_at_max = (bytes_inc == {CW{1'b1}});
  assign limit_now  = (bytes_done_q >= limit) || at_max;
  assign limit_inc  = (bytes_inc >= limit) || inc_at_max;

  always_comb begin
    busy_d       = busy_q;
    bytes_done_d = bytes_done_q;
    result_d     = '0;
    result_d.done_status = i2cmts_pkg::DoneRunning;

    if (pop_item_i.op == i2cmts_pkg::OP_START_REQ) begin
      busy_d = 1'b1;
      bytes_done_d = '0;
      result_d.enable_and_start = 1'b1;
    end else if (busy_q) begin
      case (pop_item_i.op)
        i2cmts_pkg::OP_ADDR: begin
          result_d.tx_valid    = 1'b1;
          result_d.tx_data     = slave_address_i | {7'd0, read_mode_i};
          result_d.clear_start = 1'b1;
          result_d.set_ack     = 1'b1;
          result_d.clear_flag  = 1'b1;
        end
        i2cmts_pkg::OP_ADDR_R_ACK: begin
          result_d.set_ack    = 1'b1;
          result_d.clear_flag = 1'b1;
        end
        i2cmts_pkg::OP_DATA_R_ACK: begin
          result_d.rx_valid = 1'b1;
          result_d.rx_data  = pop_item_i.rx;
          bytes_done_d      = bytes_inc;
          if (limit_inc) begin
            result_d.clear_ack   = 1'b1;
            result_d.send_stop   = 1'b1;
            result_d.clear_flag  = 1'b1;
            result_d.done_status = {1'b0, pop_item_i.status};
            busy_d = 1'b0;
          end else begin
            result_d.set_ack    = 1'b1;
            result_d.clear_flag = 1'b1;
          end
        end
        i2cmts_pkg::OP_DATA_R_NAK: begin
          result_d.rx_valid    = 1'b1;
          result_d.rx_data     = pop_item_i.rx;
          bytes_done_d         = bytes_inc;
          result_d.send_stop   = 1'b1;
          result_d.clear_flag  = 1'b1;
          result_d.done_status = {1'b0, pop_item_i.status};
          busy_d = 1'b0;
        end
        i2cmts_pkg::OP_ADDR_W_ACK: begin
          result_d.tx_valid   = 1'b1;
          result_d.tx_data    = pop_item_i.tx;
          result_d.clear_flag = 1'b1;
          bytes_done_d        = bytes_inc;
        end
        i2cmts_pkg::OP_DATA_W_ACK: begin
          if (limit_now) begin
            result_d.send_stop   = 1'b1;
            result_d.clear_flag  = 1'b1;
            result_d.done_status = {1'b0, pop_item_i.status};
            busy_d = 1'b0;
          end else begin
            result_d.tx_valid   = 1'b1;
            result_d.tx_data    = pop_item_i.tx;
            result_d.clear_flag = 1'b1;
            bytes_done_d        = bytes_inc;
          end
        end
        i2cmts_pkg::OP_ARB_LOST: begin
          result_d.set_start  = 1'b1;
          result_d.clear_flag = 1'b1;
        end
        default: begin
          result_d.send_stop   = 1'b1;
          result_d.clear_flag  = 1'b1;
          result_d.done_status = {1'b0, pop_item_i.status};
          busy_d = 1'b0;
        end
      endcase
    end

    if (pop) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      bytes_done_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        busy_q       <= busy_d;
        bytes_done_q <= bytes_done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

### hdl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns start requests and controller status events into the control
// actions of a byte-level I2C master controller.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its results are taken. An
// accepted item is classified by the front end in its accept cycle and
// written into a two-entry queue; the back end executes one queued item per
// cycle, while results are taken, against the transfer state and places its
// result in an output register, so a result passes through the queue and then
// the output register before it is presented. While a result waits to be
// taken, the queue lets the input take up to two more items.
// Configuration writes take effect at once and are meant for idle
// periods only. The clock half period is held by the controller itself, so
// writes to that register have no effect inside this block.
module i2c_master_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  status_code_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        enable_and_start_o,
  output logic        set_start_o,
  output logic        clear_start_o,
  output logic        set_ack_o,
  output logic        clear_ack_o,
  output logic        clear_flag_o,
  output logic        send_stop_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_data_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_data_o,
  output logic [8:0]  done_status_o
);

  logic [7:0]          slave_address_q;
  logic                read_mode_q;
  logic [15:0]         byte_count_q;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  i2cmts_pkg::item_t   push_item, pop_item;
  i2cmts_pkg::result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= 8'd0;
      read_mode_q     <= 1'b0;
      byte_count_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2cmts_pkg::RegSlaveAddress:  slave_address_q <= cfg_data_i[7:0];
        i2cmts_pkg::RegReadMode:      read_mode_q     <= cfg_data_i[0];
        i2cmts_pkg::RegByteCount:     byte_count_q    <= cfg_data_i;
        i2cmts_pkg::RegSclHalfPeriod: ;
        default: ;
      endcase
    end
  end

  i2cmts_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .status_code_i (status_code_i),
    .rx_byte_i     (rx_byte_i),
    .tx_byte_i     (tx_byte_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  i2cmts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  i2cmts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .slave_address_i (slave_address_q),
    .read_mode_i     (read_mode_q),
    .byte_count_i    (byte_count_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result)
  );

  assign enable_and_start_o = result.enable_and_start;
  assign set_start_o        = result.set_start;
  assign clear_start_o      = result.clear_start;
  assign set_ack_o          = result.set_ack;
  assign clear_ack_o        = result.clear_ack;
  assign clear_flag_o       = result.clear_flag;
  assign send_stop_o        = result.send_stop;
  assign tx_valid_o         = result.tx_valid;
  assign tx_data_o          = result.tx_data;
  assign rx_valid_o         = result.rx_valid;
  assign rx_data_o          = result.rx_data;
  assign done_status_o      = result.done_status;

endmodule

### hdl/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_defines.svh"

module i2cmts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        enable_and_start_o,
  input logic        set_ack_o,
  input logic        clear_ack_o,
  input logic        clear_flag_o,
  input logic        send_stop_o,
  input logic        tx_valid_o,
  input logic [8:0]  done_status_o
);

  `I2CMTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(done_status_o), "Stalled item changed or dropped.")
  `I2CMTS_ASSERT_SAME(a_ack_exclusive, out_valid_o, !(set_ack_o && clear_ack_o), "Acknowledge set and cleared together.")
  `I2CMTS_ASSERT_SAME(a_finish_stops, out_valid_o && (done_status_o != 9'h100), send_stop_o && clear_flag_o, "Finished transfer without stop.")
  `I2CMTS_ASSERT_SAME(a_start_runs, out_valid_o && enable_and_start_o, (done_status_o == 9'h100) && !tx_valid_o && !send_stop_o, "Start item carries other actions.")

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_checker (.*);
